// File: src/ibd_pkg.sv
`default_nettype none
package ibd_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 13;
	localparam int unsigned HEIGHT_LIMIT = 4096;
	localparam int unsigned ROW_W = 13;
	localparam logic [7:0] ALPHA_OUT = 8'hff;

	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_X = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_Y = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DIV1,
		S_ACC,
		S_DIV2,
		S_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic run_end;
		logic div_step;
		logic acc_step;
		logic store_wr;
		logic out_load;
		logic eor;
		logic eof;
	} cmd_t;

endpackage
`default_nettype wire

// File: src/integer_box_downscaler_top.sv
`default_nettype none
// channel   direction  tdata / fields                               tlast         tuser
// s_axis    in         red[7:0] green[15:8] blue[23:16]             -             -
// m_axis    out        out_red out_green out_blue out_alpha(255)    end_of_row    end_of_frame
// cfg       in         cfg_we, cfg_index (0 width 1 height 2 step_x 3 step_y), cfg_wdata
// a beat that does not end a run leaves the block ready for the next beat
// a beat that ends a run is divided by its run length (a 14-step divider per channel), and on a
// result beat then by the group's row count: the input waits while the serial divisions run
// arst_n clears counters, run sums, output valid; config resets to 1; row store needs no clearing
// a held result stalls the next result beat, and the input with it
module integer_box_downscaler_top #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned MAX_STEP = 64
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [ibd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [ibd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [23:0]                     s_axis_tdata,  // red, green, blue
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic [31:0]                          m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
	output logic                                 m_axis_tlast,
	output logic                                 m_axis_tuser
);
	import ibd_pkg::*;

	cmd_t cmd;
	logic div_done;
	logic [$clog2(MAX_WIDTH)-1:0] idx;
	logic [$clog2(MAX_STEP+1)-1:0] n, g;
	logic rows_nz;

	ibd_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_STEP(MAX_STEP)) u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.div_done(div_done), .cmd(cmd), .idx(idx), .n(n), .g(g), .rows_nz(rows_nz)
	);

	ibd_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_STEP(MAX_STEP)) u_dp (
		.clk(clk), .arst_n(arst_n), .pix(s_axis_tdata), .cmd(cmd), .idx(idx), .n(n),
		.g(g), .rows_nz(rows_nz), .div_done(div_done), .out_data(m_axis_tdata),
		.out_eor(m_axis_tlast), .out_eof(m_axis_tuser)
	);

endmodule
`default_nettype wire

// File: src/ibd_datapath.sv
`default_nettype none
module ibd_datapath #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned MAX_STEP = 64
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic [23:0]                        pix,
	input  wire ibd_pkg::cmd_t                      cmd,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]       idx,
	input  wire logic [$clog2(MAX_STEP+1)-1:0]      n,
	input  wire logic [$clog2(MAX_STEP+1)-1:0]      g,
	input  wire logic                               rows_nz,
	output logic                                    div_done,
	output logic [31:0]                             out_data,
	output logic                                    out_eor,
	output logic                                    out_eof
);
	import ibd_pkg::*;

	localparam int unsigned SDW = $clog2(MAX_STEP + 1);
	localparam int unsigned SW = $clog2(MAX_STEP * 255 + 1);
	localparam int unsigned CNTW = $clog2(SW + 1);

	logic [SW-1:0]   sum_q [3];
	logic [SW-1:0]   dvd_q [3];
	logic [SDW-1:0]  rem_q [3];
	logic [SDW-1:0]  dvs_q;
	logic [CNTW-1:0] cnt_q;
	logic [3*SW-1:0] mem [MAX_WIDTH];
	logic [3*SW-1:0] rd_q;
	logic [SW-1:0]   sum_nx [3];
	logic [SW-1:0]   acc [3];
	logic [SW-1:0]   dvd_nx [3];
	logic [SDW-1:0]  rem_nx [3];
	logic [SDW:0]    trial [3];
	logic [31:0]     out_q;
	logic            eor_q;
	logic            eof_q;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_nx[c] = sum_q[c] + SW'(pix[8*c +: 8]);
			acc[c] = dvd_q[c] + (rows_nz ? rd_q[SW*c +: SW] : SW'(0));
			trial[c] = {rem_q[c], dvd_q[c][SW-1]};
			if (trial[c] >= {1'b0, dvs_q}) begin
				rem_nx[c] = SDW'(trial[c] - {1'b0, dvs_q});
				dvd_nx[c] = {dvd_q[c][SW-2:0], 1'b1};
			end else begin
				rem_nx[c] = trial[c][SDW-1:0];
				dvd_nx[c] = {dvd_q[c][SW-2:0], 1'b0};
			end
		end
	end

	assign div_done = (cnt_q == CNTW'(SW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= '0;
			end
		end else if (cmd.accept) begin
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= cmd.run_end ? '0 : sum_nx[c];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rd_q <= mem[idx];
			for (int c = 0; c < 3; c++) begin
				dvd_q[c] <= sum_nx[c];
				rem_q[c] <= '0;
			end
			dvs_q <= n;
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			for (int c = 0; c < 3; c++) begin
				dvd_q[c] <= dvd_nx[c];
				rem_q[c] <= rem_nx[c];
			end
			cnt_q <= cnt_q + CNTW'(1);
		end else if (cmd.acc_step) begin
			for (int c = 0; c < 3; c++) begin
				dvd_q[c] <= acc[c];
				rem_q[c] <= '0;
			end
			dvs_q <= g;
			cnt_q <= '0;
		end
		if (cmd.store_wr) begin
			mem[idx] <= {acc[2], acc[1], acc[0]};
		end
		if (cmd.out_load) begin
			out_q <= {ALPHA_OUT, dvd_q[2][7:0], dvd_q[1][7:0], dvd_q[0][7:0]};
			eor_q <= cmd.eor;
			eof_q <= cmd.eof;
		end
	end

	assign out_data = out_q;
	assign out_eor = eor_q;
	assign out_eof = eof_q;

endmodule
`default_nettype wire

// File: src/ibd_ctrl.sv
`default_nettype none
module ibd_ctrl #(
	parameter int unsigned MAX_WIDTH = 4096,
	parameter int unsigned MAX_STEP = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [ibd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [ibd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	input  wire logic                              div_done,
	output ibd_pkg::cmd_t                          cmd,
	output logic [$clog2(MAX_WIDTH)-1:0]           idx,
	output logic [$clog2(MAX_STEP+1)-1:0]          n,
	output logic [$clog2(MAX_STEP+1)-1:0]          g,
	output logic                                   rows_nz
);
	import ibd_pkg::*;

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned SDW = $clog2(MAX_STEP + 1);
	localparam int unsigned WW = CW + 1;

	state_t state_q, state_nx;
	logic [CFG_DATA_W-1:0] width_q, height_q;
	logic [6:0] stepx_q, stepy_q;
	logic [CW-1:0] col_q, ocol_q;
	logic [ROW_W-2:0] row_q;
	logic [SDW-1:0] run_q, grp_q;
	logic out_valid_q;
	logic [CW-1:0] idx_q;
	logic [SDW-1:0] n_q, g_q;
	logic rows_nz_q, grp_end_q, last_col_q, last_row_q;

	logic [WW-1:0] w_lim;
	logic [ROW_W-1:0] h_lim;
	logic [SDW-1:0] sx_lim, sy_lim, n_nx, g_nx;
	logic last_col, last_row, grp_end, run_end, accept;

	always_comb begin
		if (width_q == '0) w_lim = WW'(1);
		else if (32'(width_q) > MAX_WIDTH) w_lim = WW'(MAX_WIDTH);
		else w_lim = WW'(width_q);
		if (height_q == '0) h_lim = ROW_W'(1);
		else if (32'(height_q) > HEIGHT_LIMIT) h_lim = ROW_W'(HEIGHT_LIMIT);
		else h_lim = height_q;
		if (stepx_q == '0) sx_lim = SDW'(1);
		else if (32'(stepx_q) > MAX_STEP) sx_lim = SDW'(MAX_STEP);
		else sx_lim = SDW'(stepx_q);
		if (stepy_q == '0) sy_lim = SDW'(1);
		else if (32'(stepy_q) > MAX_STEP) sy_lim = SDW'(MAX_STEP);
		else sy_lim = SDW'(stepy_q);
	end

	assign accept = in_valid && in_ready;
	assign n_nx = run_q + SDW'(1);
	assign g_nx = grp_q + SDW'(1);
	assign last_col = ({1'b0, col_q} + WW'(1)) >= w_lim;
	assign last_row = ({1'b0, row_q} + ROW_W'(1)) >= h_lim;
	assign grp_end = (g_nx >= sy_lim) || last_row;
	assign run_end = (n_nx >= sx_lim) || last_col;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			width_q <= CFG_DATA_W'(1);
			height_q <= CFG_DATA_W'(1);
			stepx_q <= 7'd1;
			stepy_q <= 7'd1;
			col_q <= '0;
			ocol_q <= '0;
			row_q <= '0;
			run_q <= '0;
			grp_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SOURCE_WIDTH: width_q <= cfg_wdata;
					REG_SOURCE_HEIGHT: height_q <= cfg_wdata;
					REG_STEP_X: stepx_q <= cfg_wdata[6:0];
					REG_STEP_Y: stepy_q <= cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					ocol_q <= '0;
					run_q <= '0;
					grp_q <= grp_end ? '0 : g_nx;
					row_q <= last_row ? '0 : row_q + (ROW_W-1)'(1);
				end else begin
					col_q <= col_q + CW'(1);
					if (run_end) begin
						run_q <= '0;
						ocol_q <= ocol_q + CW'(1);
					end else begin
						run_q <= n_nx;
					end
				end
			end
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q <= ocol_q;
			n_q <= n_nx;
			g_q <= g_nx;
			rows_nz_q <= (grp_q != '0);
			grp_end_q <= grp_end;
			last_col_q <= last_col;
			last_row_q <= last_row;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: if (accept && run_end) state_nx = S_DIV1;
			S_DIV1: if (div_done) state_nx = S_ACC;
			S_ACC: state_nx = grp_end_q ? S_DIV2 : S_IDLE;
			S_DIV2: if (div_done) state_nx = S_OUT;
			S_OUT: if (!out_valid_q || out_ready) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.eor = last_col_q;
		cmd.eof = last_col_q && last_row_q;
		cmd.run_end = run_end;
		unique case (state_q)
			S_IDLE: cmd.accept = in_valid;
			S_DIV1: cmd.div_step = 1'b1;
			S_ACC: begin
				cmd.acc_step = grp_end_q;
				cmd.store_wr = !grp_end_q;
			end
			S_DIV2: cmd.div_step = 1'b1;
			S_OUT: cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign idx = (state_q == S_IDLE) ? ocol_q : idx_q;
	assign n = n_nx;
	assign g = g_q;
	assign rows_nz = rows_nz_q;

`ifndef SYNTH
	a_store_only_mid_group: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.store_wr |-> !grp_end_q) else $error("store write on group end");
	a_load_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready)) else $error("result overwritten");
	a_no_run_end_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !run_end) |=> (state_q == S_IDLE)) else $error("spurious divide");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

typedef struct {
	bit [31:0] data;
	bit        row_end;
	bit        frame_end;
} box_pixel_t;

class box_average_model;
	bit [13:0]   column_sums[4096][3];
	int unsigned run_totals[3];
	int unsigned col_pos, run_len, out_col, row_pos, group_rows;
	bit [12:0]   width_reg, height_reg;
	bit [6:0]    step_x_reg, step_y_reg;
	box_pixel_t  expected_pixels[$];
	int          error_count;

	function new();
		width_reg = 1;
		height_reg = 1;
		step_x_reg = 1;
		step_y_reg = 1;
	endfunction

	function int unsigned clip(int unsigned v, int unsigned hi);
		if (v == 0)
			return 1;
		return (v > hi) ? hi : v;
	endfunction

	function void write_reg(logic [ibd_pkg::CFG_IDX_W-1:0] idx, bit [12:0] value);
		case (idx)
			ibd_pkg::REG_SOURCE_WIDTH: width_reg = value;
			ibd_pkg::REG_SOURCE_HEIGHT: height_reg = value;
			ibd_pkg::REG_STEP_X: step_x_reg = value[6:0];
			ibd_pkg::REG_STEP_Y: step_y_reg = value[6:0];
			default: ;
		endcase
	endfunction

	function bit at_frame_start();
		return col_pos == 0 && row_pos == 0 && group_rows == 0;
	endfunction

	function void predict_pixel(bit [23:0] rgb);
		int unsigned w, h, sx, sy, n, g, avg, acc;
		bit last_col, last_row, group_end;
		box_pixel_t px;
		w = clip(width_reg, 4096);
		h = clip(height_reg, ibd_pkg::HEIGHT_LIMIT);
		sx = clip(step_x_reg, 64);
		sy = clip(step_y_reg, 64);
		n = run_len + 1;
		g = group_rows + 1;
		last_col = col_pos + 1 >= w;
		last_row = row_pos + 1 >= h;
		group_end = g >= sy || last_row;
		for (int c = 0; c < 3; c++)
			run_totals[c] += rgb[8*c +: 8];
		if (n >= sx || last_col) begin
			px.data[31:24] = ibd_pkg::ALPHA_OUT;
			for (int c = 0; c < 3; c++) begin
				avg = run_totals[c] / n;
				acc = avg;
				if (group_rows != 0)
					acc += column_sums[out_col][c];
				if (group_end)
					px.data[8*c +: 8] = 8'(acc / g);
				else
					column_sums[out_col][c] = 14'(acc);
				run_totals[c] = 0;
			end
			if (group_end) begin
				px.row_end = last_col;
				px.frame_end = last_col && last_row;
				expected_pixels.push_back(px);
			end
			run_len = 0;
			out_col = (out_col + 1) & 12'hfff;
		end else begin
			run_len = n;
		end
		if (last_col) begin
			col_pos = 0;
			out_col = 0;
			run_len = 0;
			run_totals = '{0, 0, 0};
			group_rows = group_end ? 0 : g;
			row_pos = last_row ? 0 : row_pos + 1;
		end else begin
			col_pos++;
		end
	endfunction

	function void check_pixel(bit [31:0] data, bit row_end, bit frame_end);
		box_pixel_t px;
		if (expected_pixels.size() == 0) begin
			$display("%t: unexpected output beat data %h last %b user %b",
				$realtime, data, row_end, frame_end);
			error_count++;
			return;
		end
		px = expected_pixels.pop_front();
		if (px.data != data) begin
			$display("%t: tdata expected %h actual %h", $realtime, px.data, data);
			error_count++;
		end
		if (px.row_end != row_end) begin
			$display("%t: tlast expected %b actual %b", $realtime, px.row_end, row_end);
			error_count++;
		end
		if (px.frame_end != frame_end) begin
			$display("%t: tuser expected %b actual %b", $realtime, px.frame_end, frame_end);
			error_count++;
		end
	endfunction
endclass

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [ibd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [ibd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [31:0] m_axis_tdata;
	logic m_axis_tlast;
	logic m_axis_tuser;

	box_average_model model = new();
	bit calm = 0;
	int pixels_sent = 0;

	integer_box_downscaler_top dut (.*);

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	always @(negedge clk)
		m_axis_tready <= calm || $urandom_range(99) >= 24;

	always @(posedge clk)
		if (arst_n && m_axis_tvalid && m_axis_tready)
			model.check_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);

	task automatic write_reg(logic [ibd_pkg::CFG_IDX_W-1:0] idx, int value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= value[12:0];
		model.write_reg(idx, value[12:0]);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	task automatic set_frame(int w, int h, int sx, int sy);
		write_reg(ibd_pkg::REG_SOURCE_WIDTH, w);
		write_reg(ibd_pkg::REG_SOURCE_HEIGHT, h);
		write_reg(ibd_pkg::REG_STEP_X, sx);
		write_reg(ibd_pkg::REG_STEP_Y, sy);
	endtask

	function automatic bit [23:0] pick_pixel(int mode);
		case (mode)
			0: return 24'h000000;
			1: return 24'hffffff;
			default: return ($urandom_range(9) == 0) ? {3{8'(($urandom_range(1)) * 255)}}
				: 24'($urandom);
		endcase
	endfunction

	task automatic send_pixel(bit [23:0] rgb);
		while (!calm && $urandom_range(99) < 24) begin
			s_axis_tvalid <= 0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= rgb;
		do
			@(posedge clk);
		while (!s_axis_tready);
		model.predict_pixel(rgb);
		pixels_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame(int mode);
		do
			send_pixel(pick_pixel(mode < 0 ? (pixels_sent % 2) : mode));
		while (!model.at_frame_start());
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (model.expected_pixels.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	initial begin
		int w, h;
		repeat (12) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// extremes, partial runs and groups, clamping
		set_frame(4, 3, 2, 2);
		send_frame(-1);
		drain();
		set_frame(5, 3, 2, 2);
		send_frame(1);
		drain();
		set_frame(0, 0, 0, 0);
		send_frame(1);
		drain();
		set_frame(7, 2, 127, 127);
		send_frame(2);
		drain();
		calm = 1;
		set_frame(100, 0, 127, 1);
		send_frame(2);
		drain();
		calm = 0;

		// shrink step_y and height in the middle of a frame
		set_frame(6, 4, 3, 3);
		repeat (8) send_pixel(pick_pixel(2));
		drain();
		write_reg(ibd_pkg::REG_STEP_Y, 1);
		write_reg(ibd_pkg::REG_SOURCE_HEIGHT, 2);
		while (!model.at_frame_start())
			send_pixel(pick_pixel(2));
		drain();

		while (pixels_sent < 1350) begin
			calm = $urandom_range(5) == 0;
			w = ($urandom_range(7) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 24);
			h = $urandom_range(1, 6);
			set_frame(w, h, ($urandom_range(9) == 0) ? 64 : $urandom_range(1, w + 1),
				$urandom_range(1, h + 1));
			repeat ($urandom_range(1, 2)) send_frame(2);
			drain();
		end
		calm = 0;

		if (model.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

`default_nettype wire
